// ----- rtl/core/alid_pkg.sv -----
// Shared types and codes for the ordered list block.
`default_nettype none

package alid_pkg;

    // Request operation codes; codes above FIND are treated as bad requests
    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_UPDATE = 3'd4,
        MODE_FIND   = 3'd5
    } t_mode;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_NOKEY  = 2'd3;

    // Walk pointer load selection
    typedef enum logic [2:0] {
        P_NONE,
        P_CNT_M1,
        P_POS_P1,
        P_ZERO,
        P_POS
    } t_pinit;

    // Controller state
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_DN,
        S_FLUSH,
        S_PUT,
        S_GET_RD,
        S_GET_WAIT,
        S_FIND,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;
        t_pinit     pinit;
        logic       rd;
        logic       step_up;
        logic       shift;
        logic       cmp;
        logic       put;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_found;
        logic       res_data;
        logic       out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  pos_gt;
        logic  pos_ge;
        logic  pos_eq;
        logic  del_last;
        logic  ptr_at_pos;
        logic  ptr_at_last;
        logic  cnt_zero;
        logic  hit;
        logic  find_end;
        logic  wpend;
        logic  out_free;
    } t_dp_st;

endpackage

`default_nettype wire

// ----- rtl/core/alid_ctrl.sv -----
// Controller state machine sequencing each list request.
`default_nettype none

module alid_ctrl
    import alid_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_st  i_st,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_st.mode)
                    MODE_INSERT: begin
                        if (i_st.full || i_st.pos_gt) n_state = S_DONE;
                        else if (i_st.pos_eq)         n_state = S_PUT;
                        else                          n_state = S_UP;
                    end
                    MODE_DELETE: begin
                        if (i_st.pos_ge || i_st.del_last) n_state = S_DONE;
                        else                              n_state = S_DN;
                    end
                    MODE_GET: begin
                        if (i_st.pos_ge) n_state = S_DONE;
                        else             n_state = S_GET_RD;
                    end
                    MODE_UPDATE: begin
                        if (i_st.pos_ge) n_state = S_DONE;
                        else             n_state = S_PUT;
                    end
                    MODE_FIND: begin
                        if (i_st.cnt_zero) n_state = S_DONE;
                        else               n_state = S_FIND;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_UP: begin
                if (i_st.ptr_at_pos) n_state = S_FLUSH;
            end
            S_DN: begin
                if (i_st.ptr_at_last) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_st.mode == MODE_INSERT) n_state = S_PUT;
                else                          n_state = S_DONE;
            end
            S_PUT:      n_state = S_DONE;
            S_GET_RD:   n_state = S_GET_WAIT;
            S_GET_WAIT: n_state = S_DONE;
            S_FIND: begin
                if (i_st.hit || i_st.find_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Refuse input while reset is held
                o_s_tready    = i_rst_n;
                o_cmd.capture = i_s_tvalid && i_rst_n;
            end
            S_DECODE: begin
                case (i_st.mode)
                    MODE_CLEAR: begin
                        o_cmd.cnt_clr    = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                    end
                    MODE_INSERT: begin
                        if (i_st.full) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_FULL;
                        end else if (i_st.pos_gt) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BADPOS;
                        end else if (!i_st.pos_eq) begin
                            o_cmd.pinit = P_CNT_M1;
                        end
                    end
                    MODE_DELETE: begin
                        if (i_st.pos_ge) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BADPOS;
                        end else if (i_st.del_last) begin
                            o_cmd.cnt_dec    = 1'b1;
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_OK;
                        end else begin
                            o_cmd.pinit = P_POS_P1;
                        end
                    end
                    MODE_GET: begin
                        if (i_st.pos_ge) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BADPOS;
                        end else begin
                            o_cmd.pinit = P_POS;
                        end
                    end
                    MODE_UPDATE: begin
                        if (i_st.pos_ge) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_BADPOS;
                        end
                    end
                    MODE_FIND: begin
                        if (i_st.cnt_zero) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_NOKEY;
                        end else begin
                            o_cmd.pinit = P_ZERO;
                        end
                    end
                    default: begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_BADPOS;
                    end
                endcase
            end
            S_UP: begin
                o_cmd.rd    = 1'b1;
                o_cmd.shift = 1'b1;
            end
            S_DN: begin
                o_cmd.rd      = 1'b1;
                o_cmd.shift   = 1'b1;
                o_cmd.step_up = 1'b1;
            end
            S_FLUSH: begin
                if (i_st.mode != MODE_INSERT) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                end
            end
            S_PUT: begin
                o_cmd.put        = 1'b1;
                o_cmd.cnt_inc    = (i_st.mode == MODE_INSERT);
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
            end
            S_GET_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_GET_WAIT: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_data   = 1'b1;
            end
            S_FIND: begin
                if (i_st.hit) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_found  = 1'b1;
                end else if (i_st.find_end) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_NOKEY;
                end else begin
                    o_cmd.rd      = 1'b1;
                    o_cmd.cmp     = 1'b1;
                    o_cmd.step_up = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_st.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/alid_dp.sv -----
// Datapath: request registers, record store, walk pointer, count and result registers.
`default_nettype none

module alid_dp
    import alid_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [2:0]    i_mode,
    input  wire logic [4:0]    i_position,
    input  wire logic          i_append,
    input  wire logic [63:0]   i_item_key,
    input  wire logic [31:0]   i_item_payload,
    input  wire t_dp_cmd       i_cmd,
    output t_dp_st             o_st,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [4:0]         o_found_position,
    output logic [63:0]        o_out_key,
    output logic [31:0]        o_out_payload,
    output logic [5:0]         o_entry_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > 5) ? CW : 5;
    localparam int WW    = KEY_BITS + PAYLOAD_BITS;
    localparam int PEXTW = (PAYLOAD_BITS > 32) ? PAYLOAD_BITS : 32;

    // Record store: key in the upper bits, payload in the lower bits
    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd_word;

    // Request registers
    t_mode                   r_mode;
    logic [4:0]              r_pos;
    logic                    r_app;
    logic [KEY_BITS-1:0]     r_req_key;
    logic [PAYLOAD_BITS-1:0] r_req_pay;

    // Walk and control registers
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_waddr;
    logic          r_wpend;
    logic [AW-1:0] r_cmp_addr;
    logic          r_cmp_pend;

    // Result and output registers
    logic [1:0]              r_res_status;
    logic [AW-1:0]           r_res_found;
    logic [KEY_BITS-1:0]     r_res_key;
    logic [PAYLOAD_BITS-1:0] r_res_pay;
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [4:0]              r_out_found;
    logic [63:0]             r_out_key;
    logic [31:0]             r_out_pay;
    logic [5:0]              r_out_cnt;

    logic [CMPW-1:0]         w_cnt_ext;
    logic [CMPW-1:0]         w_pos_eff;
    logic [CMPW-1:0]         w_ptr_ext;
    logic [CMPW-1:0]         w_cmp_ext;
    logic [CW-1:0]           w_cnt_m1;
    logic [CMPW-1:0]         w_pos_p1;
    logic [PEXTW-1:0]        w_pay_ext;
    logic [KEY_BITS-1:0]     w_rd_key;
    logic [PAYLOAD_BITS-1:0] w_rd_pay;
    logic                    w_we;
    logic [AW-1:0]           w_wa;
    logic [WW-1:0]           w_wd;
    logic                    w_out_free;

    // Effective position: an append inserts at the current count
    assign w_cnt_ext = CMPW'(r_cnt);
    assign w_pos_eff = (r_app && (r_mode == MODE_INSERT)) ? w_cnt_ext : CMPW'(r_pos);
    assign w_ptr_ext = CMPW'(r_ptr);
    assign w_cmp_ext = CMPW'(r_cmp_addr);
    assign w_cnt_m1  = r_cnt - CW'(1);
    assign w_pos_p1  = w_pos_eff + CMPW'(1);
    assign w_pay_ext = PEXTW'(i_item_payload);
    assign w_rd_key  = r_rd_word[WW-1:PAYLOAD_BITS];
    assign w_rd_pay  = r_rd_word[PAYLOAD_BITS-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    // Status to the controller
    always_comb begin
        o_st.mode        = r_mode;
        o_st.full        = (r_cnt == CW'(DEPTH));
        o_st.pos_gt      = (w_pos_eff > w_cnt_ext);
        o_st.pos_ge      = (w_pos_eff >= w_cnt_ext);
        o_st.pos_eq      = (w_pos_eff == w_cnt_ext);
        o_st.del_last    = (w_pos_p1 == w_cnt_ext);
        o_st.ptr_at_pos  = (w_ptr_ext == w_pos_eff);
        o_st.ptr_at_last = ((w_ptr_ext + CMPW'(1)) == w_cnt_ext);
        o_st.cnt_zero    = (r_cnt == '0);
        o_st.hit         = r_cmp_pend && (w_rd_key == r_req_key);
        o_st.find_end    = r_cmp_pend && ((w_cmp_ext + CMPW'(1)) == w_cnt_ext);
        o_st.wpend       = r_wpend;
        o_st.out_free    = w_out_free;
    end

    // Write port: a pending shift write, else a new record at the position
    always_comb begin
        w_we = r_wpend || i_cmd.put;
        if (r_wpend) begin
            w_wa = r_waddr;
            w_wd = r_rd_word;
        end else begin
            w_wa = w_pos_eff[AW-1:0];
            w_wd = {r_req_key, r_req_pay};
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd) begin
            r_rd_word <= r_mem[r_ptr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_wpend     <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wpend    <= i_cmd.rd && i_cmd.shift;
            r_cmp_pend <= i_cmd.rd && i_cmd.cmp;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= w_cnt_m1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, walk pointer and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= t_mode'(i_mode);
            r_pos     <= i_position;
            r_app     <= i_append;
            r_req_key <= KEY_BITS'(i_item_key);
            r_req_pay <= w_pay_ext[PAYLOAD_BITS-1:0];
        end
        case (i_cmd.pinit)
            P_CNT_M1: r_ptr <= w_cnt_m1[AW-1:0];
            P_POS_P1: r_ptr <= w_pos_p1[AW-1:0];
            P_ZERO:   r_ptr <= '0;
            P_POS:    r_ptr <= w_pos_eff[AW-1:0];
            default: begin
                if (i_cmd.rd) begin
                    r_ptr <= i_cmd.step_up ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
                end
            end
        endcase
        if (i_cmd.rd) begin
            r_waddr    <= i_cmd.step_up ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
            r_cmp_addr <= r_ptr;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_found  <= i_cmd.res_found ? r_cmp_addr : '0;
            r_res_key    <= i_cmd.res_data ? w_rd_key : '0;
            r_res_pay    <= i_cmd.res_data ? w_rd_pay : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= 5'(r_res_found);
            r_out_key    <= 64'(r_res_key);
            r_out_pay    <= 32'(r_res_pay);
            r_out_cnt    <= 6'(r_cnt);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_found;
    assign o_out_key        = r_out_key;
    assign o_out_payload    = r_out_pay;
    assign o_entry_count    = r_out_cnt;

endmodule

`default_nettype wire

// ----- rtl/core/array_list_insert_delete_find.sv -----
// Top level of the ordered positional list: stream ports, controller and datapath.
//
// Keeps up to DEPTH records (key, payload) packed from slot 0 and serves one
// request per input item: clear, insert, delete, get, update or find by key.
// Each request gives exactly one result item carrying status and entry count.
// Input channel i_s_axis_*: operation code in tuser, the rest in tdata.
// Output channel o_m_axis_*: status, found slot, key, payload and count.
// One request is worked at a time; the records sit in a store with one write
// and one registered read port, and insert, delete and find walk it one slot
// a cycle. The result waits in an output register and the next item is taken
// in the cycle after it is written there. A stalled receiver holds the block
// only when a second result is ready. Reset refuses input, empties the list
// and drops any pending result; the record store itself is not cleared and
// needs no clearing pass.
`default_nettype none

module array_list_insert_delete_find
    import alid_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int KEY_BITS     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // position[4:0], append[5], item_key[69:6], item_payload[101:70], zero[103:102]
    input  wire logic [103:0] i_s_axis_tdata,
    // mode[2:0]
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // status[1:0], found_position[6:2], out_key[70:7], out_payload[102:71],
    // entry_count[108:103], zero[111:109]
    output logic [111:0]      o_m_axis_tdata
);

    t_dp_cmd     w_cmd;
    t_dp_st      w_st;
    logic [1:0]  w_status;
    logic [4:0]  w_found;
    logic [63:0] w_key;
    logic [31:0] w_pay;
    logic [5:0]  w_cnt;

    // Sequencer
    alid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // Store and registers
    alid_dp #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (i_s_axis_tuser),
        .i_position       (i_s_axis_tdata[4:0]),
        .i_append         (i_s_axis_tdata[5]),
        .i_item_key       (i_s_axis_tdata[69:6]),
        .i_item_payload   (i_s_axis_tdata[101:70]),
        .i_cmd            (w_cmd),
        .o_st             (w_st),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_status         (w_status),
        .o_found_position (w_found),
        .o_out_key        (w_key),
        .o_out_payload    (w_pay),
        .o_entry_count    (w_cnt)
    );

    // Pack the result item
    assign o_m_axis_tdata = {3'b000, w_cnt, w_pay, w_key, w_found, w_status};

    // A shift write never meets a new record write
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_st.wpend && w_cmd.put))
        else $error("shift write and record write in the same cycle");

    // A result is only loaded once the previous one has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_st.out_free)
        else $error("result register overwritten before being taken");

    // An accepted item blocks further input while it is worked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture |=> !o_s_axis_tready)
        else $error("input taken while a request is in progress");

    // No shift write is left pending once the block is ready again
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_st.wpend)
        else $error("shift write pending while idle");

endmodule

`default_nettype wire
